// File: design/ffra_pkg.sv
// Package for the first-fit region allocator.
// Holds field widths, operation/status codes, payload structs and cell control types.
// No dependencies.
`timescale 1ns / 1ps

package ffra_pkg;

  // Field widths fixed by the transaction format
  localparam int ADDR_W    = 48;
  localparam int HELD_W    = 7;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Highest address a freed region may reach (exclusive end saturates here)
  localparam logic [ADDR_W-1:0] ADDR_LIMIT = 48'h8000_0000_0000;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FIT     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LIMIT = 1'd1;

  // Request and result payloads
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
  } alloc_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [STAT_W-1:0] status;
    logic [HELD_W-1:0] regions_held;
  } alloc_rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    S_LOAD,
    S_IDLE,
    S_EVAL,
    S_UPDATE
  } state_t;

  // Command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_EVAL_FIT,
    CMD_EVAL_POS,
    CMD_ALLOC,
    CMD_INSERT,
    CMD_LOAD
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] new_base;
    logic [ADDR_W-1:0] new_limit;
  } cell_ctl_t;

  // One free region: base and exclusive limit
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
  } region_t;

  // Ripple signals passed from a cell to the next higher one
  typedef struct packed {
    logic found;  // some lower cell already matched
    logic rm;     // a lower (or this) cell is removing its region
  } cell_link_t;

endpackage

// File: design/first_fit_region_allocator.sv
// Top level of the first-fit region allocator: controller, config registers, cell chain.
// Depends on ffra_pkg and ffra_cell.
`timescale 1ns / 1ps

// Every transaction passes an evaluate state, in which all cells compare their region
// against the request in parallel, and an update state, in which the first matching
// cell (found by a ripple along the cell chain) grants, and the cells above it shift
// to remove or insert a region. The result is strobed on out_valid for one cycle right
// after the update, and busy is already low in that cycle, so a new request can be
// accepted while the result is strobed; none is accepted while busy. The result must be
// captured when strobed. After reset the block is busy in a load state while it loads
// the initial region. Configuration writes are always taken (cfg_ready is tied high).
module first_fit_region_allocator #(
  parameter int MAX_REGIONS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ffra_pkg::alloc_req_t               in_data,
  output logic                               out_valid,
  output ffra_pkg::alloc_rsp_t               out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ffra_pkg::ADDR_W-1:0]        cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  ffra_pkg::state_t            state_r, state_nxt;
  logic [ffra_pkg::OP_W-1:0]   op_r;
  logic [ffra_pkg::ADDR_W-1:0] addr_r;
  logic [ffra_pkg::ADDR_W-1:0] len_r;
  logic [ffra_pkg::ADDR_W-1:0] free_end_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [ffra_pkg::ADDR_W-1:0] init_base_r;
  logic [ffra_pkg::ADDR_W-1:0] init_limit_r;
  logic                        out_valid_r, out_valid_nxt;
  ffra_pkg::alloc_rsp_t        out_data_r, out_data_nxt;

  logic                        accept;
  logic [ffra_pkg::ADDR_W:0]   free_sum;
  logic [ffra_pkg::ADDR_W-1:0] free_end;
  logic [ffra_pkg::ADDR_W-1:0] grant_any;
  ffra_pkg::cell_ctl_t         ctl;

  ffra_pkg::region_t           rgn   [MAX_REGIONS];
  ffra_pkg::region_t           lower [MAX_REGIONS];
  ffra_pkg::region_t           upper [MAX_REGIONS];
  ffra_pkg::cell_link_t        link  [MAX_REGIONS+1];
  logic [ffra_pkg::ADDR_W-1:0] grant [MAX_REGIONS];

  assign busy      = state_r != ffra_pkg::S_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // End of a freed region, saturated at the address limit
  assign free_sum = {1'b0, in_data.address} + {1'b0, in_data.length};
  assign free_end = ((in_data.address >= ffra_pkg::ADDR_LIMIT) ||
                     (free_sum > {1'b0, ffra_pkg::ADDR_LIMIT}))
                    ? ffra_pkg::ADDR_LIMIT : free_sum[ffra_pkg::ADDR_W-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_base_r  <= '0;
      init_limit_r <= ffra_pkg::ADDR_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ffra_pkg::CFG_INITIAL_BASE:  init_base_r  <= cfg_wdata;
        ffra_pkg::CFG_INITIAL_LIMIT: init_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_data.operation;
      addr_r     <= in_data.address;
      len_r      <= in_data.length;
      free_end_r <= free_end;
    end
  end

  // Cell chain
  assign link[0] = '0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    if (i == 0) begin : g_lo
      assign lower[i] = '0;
    end else begin : g_lo
      assign lower[i] = rgn[i-1];
    end
    if (i == MAX_REGIONS - 1) begin : g_hi
      assign upper[i] = '0;
    end else begin : g_hi
      assign upper[i] = rgn[i+1];
    end

    ffra_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .lower    (lower[i]),
      .upper    (upper[i]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .rgn      (rgn[i]),
      .grant    (grant[i])
    );
  end

  // Winner's base (at most one cell drives a nonzero grant)
  always_comb begin
    grant_any = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      grant_any = grant_any | grant[i];
    end
  end

  // Controller: next state, cell command, result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ctl.cmd       = ffra_pkg::CMD_HOLD;
    ctl.length    = len_r;
    ctl.new_base  = addr_r;
    ctl.new_limit = free_end_r;

    unique case (state_r)
      ffra_pkg::S_LOAD: begin
        ctl.cmd       = ffra_pkg::CMD_LOAD;
        ctl.new_base  = init_base_r;
        ctl.new_limit = init_limit_r;
        count_nxt     = CNT_W'(1);
        state_nxt     = ffra_pkg::S_IDLE;
      end
      ffra_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = ffra_pkg::S_EVAL;
        end
      end
      ffra_pkg::S_EVAL: begin
        if (op_r == ffra_pkg::OP_ALLOC) begin
          ctl.cmd = ffra_pkg::CMD_EVAL_FIT;
        end else if (op_r == ffra_pkg::OP_FREE) begin
          ctl.cmd = ffra_pkg::CMD_EVAL_POS;
        end
        state_nxt = ffra_pkg::S_UPDATE;
      end
      ffra_pkg::S_UPDATE: begin
        out_valid_nxt                = 1'b1;
        out_data_nxt.granted_address = '0;
        out_data_nxt.status          = ffra_pkg::STAT_OK;
        case (op_r)
          ffra_pkg::OP_ALLOC: begin
            ctl.cmd = ffra_pkg::CMD_ALLOC;
            if (link[MAX_REGIONS].found) begin
              out_data_nxt.granted_address = grant_any;
            end else begin
              out_data_nxt.status = ffra_pkg::STAT_NO_FIT;
            end
            if (link[MAX_REGIONS].rm) begin
              count_nxt = count_r - CNT_W'(1);
            end
          end
          ffra_pkg::OP_FREE: begin
            if (count_r >= CNT_W'(MAX_REGIONS)) begin
              out_data_nxt.status = ffra_pkg::STAT_TABLE_FULL;
            end else begin
              ctl.cmd   = ffra_pkg::CMD_INSERT;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          ffra_pkg::OP_INIT: begin
            ctl.cmd       = ffra_pkg::CMD_LOAD;
            ctl.new_base  = init_base_r;
            ctl.new_limit = init_limit_r;
            count_nxt     = CNT_W'(1);
          end
          default: ;
        endcase
        out_data_nxt.regions_held = ffra_pkg::HELD_W'(count_nxt);
        state_nxt                 = ffra_pkg::S_IDLE;
      end
      default: state_nxt = ffra_pkg::S_IDLE;
    endcase
  end

  // Controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffra_pkg::S_LOAD;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Checks
  a_strobe_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ffra_pkg::S_UPDATE)
    else $error("result strobe without an update cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REGIONS))
    else $error("region count above table depth");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ffra_pkg::S_EVAL)
    else $error("accepted transaction did not enter evaluation");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ffra_pkg::STAT_TABLE_FULL)
      |-> count_r == CNT_W'(MAX_REGIONS))
    else $error("table full reported with free entries");

  a_nofit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffra_pkg::S_UPDATE && op_r == ffra_pkg::OP_ALLOC &&
     !link[MAX_REGIONS].found) |=> $stable(count_r))
    else $error("failed allocate changed the region count");

endmodule

// File: design/ffra_cell.sv
// One cell of the region table: holds a single free region and its search flag.
// Shifts with its neighbors on insert and remove. Depends on ffra_pkg.
`timescale 1ns / 1ps

module ffra_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  ffra_pkg::cell_ctl_t  ctl,
  input  logic [CNT_W-1:0]     count,
  input  ffra_pkg::region_t    lower,
  input  ffra_pkg::region_t    upper,
  input  ffra_pkg::cell_link_t link_in,
  output ffra_pkg::cell_link_t link_out,
  output ffra_pkg::region_t    rgn,
  output logic [ffra_pkg::ADDR_W-1:0] grant
);

  logic [ffra_pkg::ADDR_W-1:0] base_r, base_nxt;
  logic [ffra_pkg::ADDR_W-1:0] limit_r, limit_nxt;
  logic [ffra_pkg::ADDR_W-1:0] sum_r;
  logic                        flag_r;
  logic                        empty_r;

  logic                        occ;
  logic [ffra_pkg::ADDR_W:0]   sum_full;
  logic                        fit;
  logic                        ge;
  logic                        first;

  assign occ = count > CNT_W'(IDX);

  // Fit test: base + length <= limit, or zero length fits anything held
  assign sum_full = {1'b0, base_r} + {1'b0, ctl.length};
  assign fit = occ && ((sum_full <= {1'b0, limit_r}) || (ctl.length == '0));
  // Insert point: first held region whose base is not below the address, else the tail
  assign ge  = !occ || (base_r >= ctl.new_base);

  // First matching cell along the chain
  assign first          = flag_r && !link_in.found;
  assign link_out.found = link_in.found || flag_r;
  assign link_out.rm    = link_in.rm || (first && empty_r);

  assign grant = first ? base_r : '0;
  assign rgn.base  = base_r;
  assign rgn.limit = limit_r;

  // Next region contents
  always_comb begin
    base_nxt  = base_r;
    limit_nxt = limit_r;
    case (ctl.cmd)
      ffra_pkg::CMD_ALLOC: begin
        if (link_out.rm) begin
          base_nxt  = upper.base;
          limit_nxt = upper.limit;
        end else if (first) begin
          base_nxt = sum_r;
        end
      end
      ffra_pkg::CMD_INSERT: begin
        if (first) begin
          base_nxt  = ctl.new_base;
          limit_nxt = ctl.new_limit;
        end else if (link_in.found) begin
          base_nxt  = lower.base;
          limit_nxt = lower.limit;
        end
      end
      ffra_pkg::CMD_LOAD: begin
        if (IDX == 0) begin
          base_nxt  = ctl.new_base;
          limit_nxt = ctl.new_limit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    limit_r <= limit_nxt;
    if (ctl.cmd == ffra_pkg::CMD_EVAL_FIT) begin
      flag_r  <= fit;
      sum_r   <= sum_full[ffra_pkg::ADDR_W-1:0];
      empty_r <= sum_full[ffra_pkg::ADDR_W-1:0] >= limit_r;
    end else if (ctl.cmd == ffra_pkg::CMD_EVAL_POS) begin
      flag_r <= ge;
    end
  end

endmodule
